// ===== rtl/accel_two_point_to_milli_g_assert.svh =====
// Assertion macros for the two-point accelerometer calibration block.
// Used by the top level; needs clk_i and rst_ni in the including scope.
`ifndef ACCEL_TWO_POINT_TO_MILLI_G_ASSERT_SVH
`define ACCEL_TWO_POINT_TO_MILLI_G_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ATPM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("atpm: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define ATPM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("atpm: next-cycle check failed");

`endif

// ===== rtl/atpm_pkg.sv =====
// Shared types and constants for the two-point accelerometer calibration block.
// No dependencies.
package atpm_pkg;

  localparam int SampleBitsDef = 10;
  localparam int AxisBits      = 2;
  localparam int NumAxes       = 3;
  localparam int RegIdxBits    = 3;
  localparam int MgPerG        = 1000;
  localparam int MgPerGBits    = 10;
  localparam int MilliGBits    = 16;
  localparam int MilliGMax     = 32767;
  localparam int MilliGMinMag  = 32768;
  localparam int PlusGReset    = 1023;

  typedef enum logic [RegIdxBits-1:0] {
    REG_MINUS_X,
    REG_PLUS_X,
    REG_MINUS_Y,
    REG_PLUS_Y,
    REG_MINUS_Z,
    REG_PLUS_Z
  } atpm_reg_e;

  typedef enum logic [AxisBits-1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } atpm_axis_e;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_SAT,
    STATUS_ZERO_SENS
  } atpm_status_e;

  typedef struct packed {
    logic neg;
    logic zero_sens;
  } atpm_side_t;

endpackage

// ===== rtl/atpm_prep.sv =====
// First stage: axis calibration select, zero point, sensitivity and offset magnitude.
// Depends on atpm_pkg.
module atpm_prep #(
  parameter int SAMPLE_BITS = atpm_pkg::SampleBitsDef
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          en_i,
  input  logic                                          valid_i,
  input  logic [SAMPLE_BITS-1:0]                        sample_i,
  input  logic [atpm_pkg::AxisBits-1:0]                 axis_i,
  input  logic [atpm_pkg::NumAxes-1:0][SAMPLE_BITS-1:0] minus_i,
  input  logic [atpm_pkg::NumAxes-1:0][SAMPLE_BITS-1:0] plus_i,
  output logic                                          valid_o,
  output logic [SAMPLE_BITS-1:0]                        diff_mag_o,
  output logic [SAMPLE_BITS-2:0]                        sens_mag_o,
  output atpm_pkg::atpm_side_t                          side_o
);

  logic [SAMPLE_BITS-1:0]   lo;
  logic [SAMPLE_BITS-1:0]   hi;
  logic                     axis_ok;
  logic [SAMPLE_BITS:0]     sum;
  logic [SAMPLE_BITS-1:0]   zero;
  logic signed [SAMPLE_BITS:0] span;
  logic signed [SAMPLE_BITS:0] diff;
  logic [SAMPLE_BITS-1:0]   span_abs;

  logic                     valid_q;
  logic [SAMPLE_BITS-1:0]   diff_mag_d, diff_mag_q;
  logic [SAMPLE_BITS-2:0]   sens_mag_d, sens_mag_q;
  atpm_pkg::atpm_side_t     side_d, side_q;

  always_comb begin
    lo      = '0;
    hi      = '0;
    axis_ok = 1'b1;
    case (atpm_pkg::atpm_axis_e'(axis_i))
      atpm_pkg::AXIS_X: begin
        lo = minus_i[0];
        hi = plus_i[0];
      end
      atpm_pkg::AXIS_Y: begin
        lo = minus_i[1];
        hi = plus_i[1];
      end
      atpm_pkg::AXIS_Z: begin
        lo = minus_i[2];
        hi = plus_i[2];
      end
      default: axis_ok = 1'b0;
    endcase
  end

  assign sum  = {1'b0, hi} + {1'b0, lo};
  assign zero = sum[SAMPLE_BITS:1];
  assign span = $signed({1'b0, hi}) - $signed({1'b0, lo});
  assign diff = $signed({1'b0, sample_i}) - $signed({1'b0, zero});

  assign span_abs   = span[SAMPLE_BITS] ? SAMPLE_BITS'(-span) : SAMPLE_BITS'(span);
  assign diff_mag_d = diff[SAMPLE_BITS] ? SAMPLE_BITS'(-diff) : SAMPLE_BITS'(diff);
  assign sens_mag_d = span_abs[SAMPLE_BITS-1:1];

  assign side_d.neg       = diff[SAMPLE_BITS] ^ span[SAMPLE_BITS];
  assign side_d.zero_sens = !axis_ok || (sens_mag_d == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      diff_mag_q <= diff_mag_d;
      sens_mag_q <= sens_mag_d;
      side_q     <= side_d;
    end
  end

  assign valid_o    = valid_q;
  assign diff_mag_o = diff_mag_q;
  assign sens_mag_o = sens_mag_q;
  assign side_o     = side_q;

endmodule

// ===== rtl/atpm_mul.sv =====
// Second stage: scale the offset magnitude to milli-g units.
// Depends on atpm_pkg.
module atpm_mul #(
  parameter int SAMPLE_BITS = atpm_pkg::SampleBitsDef
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          en_i,
  input  logic                                          valid_i,
  input  logic [SAMPLE_BITS-1:0]                        diff_mag_i,
  input  logic [SAMPLE_BITS-2:0]                        sens_mag_i,
  input  atpm_pkg::atpm_side_t                          side_i,
  output logic                                          valid_o,
  output logic [SAMPLE_BITS+atpm_pkg::MgPerGBits-1:0]   prod_o,
  output logic [SAMPLE_BITS-2:0]                        sens_mag_o,
  output atpm_pkg::atpm_side_t                          side_o
);

  localparam int ProdBits = SAMPLE_BITS + atpm_pkg::MgPerGBits;

  logic                  valid_q;
  logic [ProdBits-1:0]   prod_d, prod_q;
  logic [SAMPLE_BITS-2:0] sens_mag_q;
  atpm_pkg::atpm_side_t  side_q;

  assign prod_d = ProdBits'(diff_mag_i) * ProdBits'(atpm_pkg::MgPerG);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q     <= prod_d;
      sens_mag_q <= sens_mag_i;
      side_q     <= side_i;
    end
  end

  assign valid_o    = valid_q;
  assign prod_o     = prod_q;
  assign sens_mag_o = sens_mag_q;
  assign side_o     = side_q;

endmodule

// ===== rtl/atpm_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, sideband carried along.
// Depends on atpm_pkg.
module atpm_div #(
  parameter int NUM_BITS = atpm_pkg::SampleBitsDef + atpm_pkg::MgPerGBits,
  parameter int DEN_BITS = atpm_pkg::SampleBitsDef - 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [NUM_BITS-1:0]  num_i,
  input  logic [DEN_BITS-1:0]  den_i,
  input  atpm_pkg::atpm_side_t side_i,
  output logic                 valid_o,
  output logic [NUM_BITS-1:0]  quo_o,
  output atpm_pkg::atpm_side_t side_o
);

  logic                 valid_s [NUM_BITS];
  logic [NUM_BITS-1:0]  nq_s    [NUM_BITS];
  logic [DEN_BITS-1:0]  rem_s   [NUM_BITS];
  logic [DEN_BITS-1:0]  den_s   [NUM_BITS];
  atpm_pkg::atpm_side_t side_s  [NUM_BITS];

  for (genvar k = 0; k < NUM_BITS; k++) begin : g_stage
    logic                 valid_in;
    logic [NUM_BITS-1:0]  nq_in;
    logic [DEN_BITS-1:0]  rem_in;
    logic [DEN_BITS-1:0]  den_in;
    atpm_pkg::atpm_side_t side_in;
    logic [DEN_BITS:0]    trial;
    logic                 take;
    logic                 valid_q;
    logic [NUM_BITS-1:0]  nq_d, nq_q;
    logic [DEN_BITS-1:0]  rem_d, rem_q;
    logic [DEN_BITS-1:0]  den_q;
    atpm_pkg::atpm_side_t side_q;

    if (k == 0) begin : g_first
      assign valid_in = valid_i;
      assign nq_in    = num_i;
      assign rem_in   = '0;
      assign den_in   = den_i;
      assign side_in  = side_i;
    end else begin : g_next
      assign valid_in = valid_s[k-1];
      assign nq_in    = nq_s[k-1];
      assign rem_in   = rem_s[k-1];
      assign den_in   = den_s[k-1];
      assign side_in  = side_s[k-1];
    end

    assign trial = {rem_in, nq_in[NUM_BITS-1]};
    assign take  = trial >= {1'b0, den_in};
    assign rem_d = take ? DEN_BITS'(trial - {1'b0, den_in}) : trial[DEN_BITS-1:0];
    assign nq_d  = {nq_in[NUM_BITS-2:0], take};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q <= 1'b0;
      end else if (en_i) begin
        valid_q <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q   <= nq_d;
        rem_q  <= rem_d;
        den_q  <= den_in;
        side_q <= side_in;
      end
    end

    assign valid_s[k] = valid_q;
    assign nq_s[k]    = nq_q;
    assign rem_s[k]   = rem_q;
    assign den_s[k]   = den_q;
    assign side_s[k]  = side_q;
  end

  assign valid_o = valid_s[NUM_BITS-1];
  assign quo_o   = nq_s[NUM_BITS-1];
  assign side_o  = side_s[NUM_BITS-1];

endmodule

// ===== rtl/accel_two_point_to_milli_g.sv =====
// Pipeline stages from input accept to result:
// one select stage, one scaling multiply, one divider stage per quotient bit, one output register.
// Throughput: one item per cycle; a stalled result freezes every stage of the pipeline.
// Reset clears all valid bits and loads minus readings with 0 and plus readings with 1023.
// Top level: calibration registers, pipeline stages, saturation and output register.
// Depends on atpm_pkg, atpm_prep, atpm_mul, atpm_div and the assertion macro header.
`include "accel_two_point_to_milli_g_assert.svh"

module accel_two_point_to_milli_g #(
  parameter int SAMPLE_BITS = atpm_pkg::SampleBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [atpm_pkg::RegIdxBits-1:0]      cfg_idx_i,
  input  logic [SAMPLE_BITS-1:0]               cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [SAMPLE_BITS-1:0]               sample_i,
  input  logic [atpm_pkg::AxisBits-1:0]        axis_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [atpm_pkg::MilliGBits-1:0] milli_g_o,
  output logic [1:0]                           status_o
);

  localparam int NumBits = SAMPLE_BITS + atpm_pkg::MgPerGBits;
  localparam int DenBits = SAMPLE_BITS - 1;
  localparam logic [SAMPLE_BITS-1:0] PlusReset = SAMPLE_BITS'(atpm_pkg::PlusGReset);
  localparam logic [NumBits-1:0] PosLimit = NumBits'(atpm_pkg::MilliGMax);
  localparam logic [NumBits-1:0] NegLimit = NumBits'(atpm_pkg::MilliGMinMag);
  localparam logic [atpm_pkg::MilliGBits-1:0] SatPos =
    atpm_pkg::MilliGBits'(atpm_pkg::MilliGMax);
  localparam logic [atpm_pkg::MilliGBits-1:0] SatNeg =
    atpm_pkg::MilliGBits'(atpm_pkg::MilliGMinMag);

  logic [atpm_pkg::NumAxes-1:0][SAMPLE_BITS-1:0] minus_q;
  logic [atpm_pkg::NumAxes-1:0][SAMPLE_BITS-1:0] plus_q;

  logic                   en;
  logic                   prep_valid;
  logic [SAMPLE_BITS-1:0] prep_diff_mag;
  logic [DenBits-1:0]     prep_sens_mag;
  atpm_pkg::atpm_side_t   prep_side;
  logic                   mul_valid;
  logic [NumBits-1:0]     mul_prod;
  logic [DenBits-1:0]     mul_sens_mag;
  atpm_pkg::atpm_side_t   mul_side;
  logic                   div_valid;
  logic [NumBits-1:0]     div_quo;
  atpm_pkg::atpm_side_t   div_side;

  logic                                out_valid_q;
  logic [atpm_pkg::MilliGBits-1:0]     milli_d, milli_q;
  atpm_pkg::atpm_status_e              status_d, status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < atpm_pkg::NumAxes; a++) begin
        minus_q[a] <= '0;
        plus_q[a]  <= PlusReset;
      end
    end else if (cfg_we_i) begin
      case (atpm_pkg::atpm_reg_e'(cfg_idx_i))
        atpm_pkg::REG_MINUS_X: minus_q[0] <= cfg_data_i;
        atpm_pkg::REG_PLUS_X:  plus_q[0]  <= cfg_data_i;
        atpm_pkg::REG_MINUS_Y: minus_q[1] <= cfg_data_i;
        atpm_pkg::REG_PLUS_Y:  plus_q[1]  <= cfg_data_i;
        atpm_pkg::REG_MINUS_Z: minus_q[2] <= cfg_data_i;
        atpm_pkg::REG_PLUS_Z:  plus_q[2]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // advance everything unless a finished result is held
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  atpm_prep #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_valid_i),
    .sample_i   (sample_i),
    .axis_i     (axis_i),
    .minus_i    (minus_q),
    .plus_i     (plus_q),
    .valid_o    (prep_valid),
    .diff_mag_o (prep_diff_mag),
    .sens_mag_o (prep_sens_mag),
    .side_o     (prep_side)
  );

  atpm_mul #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_mul (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (prep_valid),
    .diff_mag_i (prep_diff_mag),
    .sens_mag_i (prep_sens_mag),
    .side_i     (prep_side),
    .valid_o    (mul_valid),
    .prod_o     (mul_prod),
    .sens_mag_o (mul_sens_mag),
    .side_o     (mul_side)
  );

  atpm_div #(
    .NUM_BITS(NumBits),
    .DEN_BITS(DenBits)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mul_valid),
    .num_i   (mul_prod),
    .den_i   (mul_sens_mag),
    .side_i  (mul_side),
    .valid_o (div_valid),
    .quo_o   (div_quo),
    .side_o  (div_side)
  );

  always_comb begin
    milli_d  = '0;
    status_d = atpm_pkg::STATUS_OK;
    if (div_side.zero_sens) begin
      status_d = atpm_pkg::STATUS_ZERO_SENS;
    end else if (!div_side.neg) begin
      if (div_quo > PosLimit) begin
        milli_d  = SatPos;
        status_d = atpm_pkg::STATUS_SAT;
      end else begin
        milli_d = div_quo[atpm_pkg::MilliGBits-1:0];
      end
    end else begin
      if (div_quo > NegLimit) begin
        milli_d  = SatNeg;
        status_d = atpm_pkg::STATUS_SAT;
      end else begin
        milli_d = -div_quo[atpm_pkg::MilliGBits-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      milli_q  <= milli_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign milli_g_o   = $signed(milli_q);
  assign status_o    = status_q;

  `ATPM_ASSERT_IMP(a_zero_sens_value, out_valid_o && status_o == atpm_pkg::STATUS_ZERO_SENS, milli_g_o == '0)
  `ATPM_ASSERT_IMP(a_sat_value, out_valid_o && status_o == atpm_pkg::STATUS_SAT, milli_q == SatPos || milli_q == SatNeg)
  `ATPM_ASSERT_IMP(a_stall_cause, in_stall_o, out_valid_o && out_stall_i)
  `ATPM_ASSERT_NXT(a_flow_through, !in_stall_o && div_valid, out_valid_o)

endmodule

// ===== bench/accel_two_point_to_milli_g_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for accel_two_point_to_milli_g: directed calibration corners, random
// calibrations and samples, random idling and a long output hold; checks every result in order.
// Depends on atpm_pkg and the accel_two_point_to_milli_g RTL.
module accel_two_point_to_milli_g_tb;
  import atpm_pkg::*;

  localparam int SampleBits    = SampleBitsDef;
  localparam int SampleMax     = (1 << SampleBits) - 1;
  localparam int NumRegs       = 2 * NumAxes;
  localparam int NumRegIdx     = 1 << RegIdxBits;
  localparam int IdleMax       = 7;
  localparam int DrainCycles   = 40;
  localparam int WatchdogLimit = 2000;
  localparam int HoldCycles    = 90;
  localparam int RandomPhases  = 9;
  localparam int ItemsPerPhase = 100;
  localparam int MaxReports    = 10;
  localparam logic [AxisBits-1:0] AxisNone = AxisBits'(NumAxes);

  typedef struct packed {
    logic signed [MilliGBits-1:0] mg;
    atpm_status_e                 status;
  } reading_t;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         cfg_we_i    = 1'b0;
  logic [RegIdxBits-1:0]        cfg_idx_i   = '0;
  logic [SampleBits-1:0]        cfg_data_i  = '0;
  logic                         in_valid_i  = 1'b0;
  logic [SampleBits-1:0]        sample_i    = '0;
  logic [AxisBits-1:0]          axis_i      = '0;
  logic                         out_stall_i = 1'b0;
  logic                         in_stall_o;
  logic                         out_valid_o;
  logic signed [MilliGBits-1:0] milli_g_o;
  logic [1:0]                   status_o;

  logic [SampleBits-1:0] cal_shadow [NumRegs];
  logic [SampleBits-1:0] cal_next [NumRegs];
  reading_t              pending_readings [$];
  int                    mismatch_cnt   = 0;
  int                    idle_cycles    = 0;
  bit                    sender_idles   = 1'b1;
  bit                    receiver_idles = 1'b1;
  bit                    hold_req       = 1'b0;

  accel_two_point_to_milli_g #(
    .SAMPLE_BITS(SampleBits)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_i   (sample_i),
    .axis_i     (axis_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .milli_g_o  (milli_g_o),
    .status_o   (status_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic reading_t calc_milli_g(input logic [SampleBits-1:0] smp,
                                            input logic [AxisBits-1:0] ax);
    reading_t r;
    int       lo;
    int       hi;
    int       sens;
    int       zero;
    longint   q;
    r.mg = '0;
    r.status = STATUS_ZERO_SENS;
    case (ax)
      AXIS_X: begin
        lo = cal_shadow[REG_MINUS_X];
        hi = cal_shadow[REG_PLUS_X];
      end
      AXIS_Y: begin
        lo = cal_shadow[REG_MINUS_Y];
        hi = cal_shadow[REG_PLUS_Y];
      end
      AXIS_Z: begin
        lo = cal_shadow[REG_MINUS_Z];
        hi = cal_shadow[REG_PLUS_Z];
      end
      default: begin
        return r;
      end
    endcase
    sens = (hi - lo) / 2;
    zero = (hi + lo) / 2;
    if (sens == 0) return r;
    q = longint'(int'(smp) - zero) * MgPerG / sens;
    if (q > MilliGMax) begin
      r.mg = MilliGBits'(MilliGMax);
      r.status = STATUS_SAT;
    end else if (q < -MilliGMinMag) begin
      r.mg = MilliGBits'(-MilliGMinMag);
      r.status = STATUS_SAT;
    end else begin
      r.mg = MilliGBits'(q);
      r.status = STATUS_OK;
    end
    return r;
  endfunction

  function automatic logic [SampleBits-1:0] pick_reading();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return SampleBits'(SampleMax);
      default: return SampleBits'($urandom);
    endcase
  endfunction

  task automatic random_pair(output logic [SampleBits-1:0] lo_o,
                             output logic [SampleBits-1:0] hi_o);
    int lo;
    int hi;
    int d;
    lo = pick_reading();
    d = $urandom_range(0, 3);
    case ($urandom_range(0, 3))
      0: hi = lo + d;
      1: hi = lo - d;
      default: hi = pick_reading();
    endcase
    if (hi < 0) hi = 0;
    if (hi > SampleMax) hi = SampleMax;
    lo_o = SampleBits'(lo);
    hi_o = SampleBits'(hi);
  endtask

  task automatic send_item(input logic [SampleBits-1:0] smp, input logic [AxisBits-1:0] ax);
    int gap;
    gap = sender_idles ? $urandom_range(0, IdleMax) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= smp;
    axis_i     <= ax;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_readings.push_back(calc_milli_g(smp, ax));
  endtask

  task automatic send_random_item();
    logic [AxisBits-1:0]   ax;
    logic [SampleBits-1:0] smp;
    ax = ($urandom_range(0, 15) == 0) ? AxisNone : AxisBits'($urandom_range(0, NumAxes - 1));
    case ($urandom_range(0, 7))
      0: smp = '0;
      1: smp = SampleBits'(SampleMax);
      default: smp = SampleBits'($urandom);
    endcase
    send_item(smp, ax);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_calibration(input bit touch_spare);
    drain_results();
    for (int i = 0; i < NumRegs; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= RegIdxBits'(i);
      cfg_data_i <= cal_next[i];
      @(posedge clk_i);
      cal_shadow[i] = cal_next[i];
    end
    if (touch_spare) begin
      for (int i = NumRegs; i < NumRegIdx; i++) begin
        cfg_we_i   <= 1'b1;
        cfg_idx_i  <= RegIdxBits'(i);
        cfg_data_i <= SampleBits'($urandom);
        @(posedge clk_i);
      end
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_reset_calibration();
    send_item('0, AXIS_X);
    send_item(SampleBits'(SampleMax), AXIS_X);
    send_item(SampleBits'(511), AXIS_Y);
    send_item(SampleBits'(512), AXIS_Y);
    send_item('0, AXIS_Z);
    send_item(SampleBits'(SampleMax), AXIS_Z);
    send_item(SampleBits'(300), AxisNone);
    send_item(SampleBits'(SampleMax), AxisNone);
  endtask

  task automatic test_calibration_corners();
    cal_next[REG_MINUS_X] = SampleBits'(512);
    cal_next[REG_PLUS_X]  = SampleBits'(512);
    cal_next[REG_MINUS_Y] = SampleBits'(600);
    cal_next[REG_PLUS_Y]  = SampleBits'(601);
    cal_next[REG_MINUS_Z] = SampleBits'(SampleMax);
    cal_next[REG_PLUS_Z]  = '0;
    write_calibration(1'b0);
    send_item(SampleBits'(700), AXIS_X);
    send_item(SampleBits'(601), AXIS_Y);
    send_item('0, AXIS_Z);
    send_item(SampleBits'(SampleMax), AXIS_Z);
    send_item(SampleBits'(512), AXIS_Z);
  endtask

  task automatic test_saturation();
    cal_next[REG_MINUS_X] = SampleBits'(500);
    cal_next[REG_PLUS_X]  = SampleBits'(502);
    cal_next[REG_MINUS_Y] = SampleBits'(1);
    cal_next[REG_PLUS_Y]  = '0;
    cal_next[REG_MINUS_Z] = '0;
    cal_next[REG_PLUS_Z]  = SampleBits'(3);
    write_calibration(1'b0);
    send_item('0, AXIS_X);
    send_item(SampleBits'(SampleMax), AXIS_X);
    send_item(SampleBits'(501), AXIS_X);
    send_item(SampleBits'(534), AXIS_X);
    send_item(SampleBits'(533), AXIS_X);
    send_item('0, AXIS_Y);
    send_item(SampleBits'(1), AXIS_Z);
    send_item('0, AXIS_Z);
  endtask

  task automatic test_spare_register_writes();
    random_pair(cal_next[REG_MINUS_X], cal_next[REG_PLUS_X]);
    random_pair(cal_next[REG_MINUS_Y], cal_next[REG_PLUS_Y]);
    random_pair(cal_next[REG_MINUS_Z], cal_next[REG_PLUS_Z]);
    write_calibration(1'b1);
    repeat (10) send_random_item();
  endtask

  task automatic test_random_calibrations();
    for (int p = 0; p < RandomPhases; p++) begin
      random_pair(cal_next[REG_MINUS_X], cal_next[REG_PLUS_X]);
      random_pair(cal_next[REG_MINUS_Y], cal_next[REG_PLUS_Y]);
      random_pair(cal_next[REG_MINUS_Z], cal_next[REG_PLUS_Z]);
      if (p == 1) begin
        for (int i = 0; i < NumRegs; i++) begin
          cal_next[i] = (i % 2 == 0) ? SampleBits'(SampleMax) : '0;
        end
      end else if (p == 2) begin
        for (int i = 0; i < NumRegs; i++) begin
          cal_next[i] = (i % 2 == 0) ? '0 : SampleBits'(SampleMax);
        end
      end
      sender_idles   = ($urandom_range(0, 3) != 0);
      receiver_idles = ($urandom_range(0, 3) != 0);
      write_calibration($urandom_range(0, 3) == 0);
      repeat (ItemsPerPhase) send_random_item();
    end
  endtask

  task automatic test_output_hold();
    sender_idles   = 1'b0;
    receiver_idles = 1'b1;
    hold_req       = 1'b1;
    repeat (80) send_random_item();
    drain_results();
    sender_idles = 1'b1;
    repeat (40) send_random_item();
  endtask

  initial begin
    cal_shadow[REG_MINUS_X] = '0;
    cal_shadow[REG_PLUS_X]  = SampleBits'(PlusGReset);
    cal_shadow[REG_MINUS_Y] = '0;
    cal_shadow[REG_PLUS_Y]  = SampleBits'(PlusGReset);
    cal_shadow[REG_MINUS_Z] = '0;
    cal_shadow[REG_PLUS_Z]  = SampleBits'(PlusGReset);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_calibration();
    test_calibration_corners();
    test_saturation();
    test_spare_register_writes();
    test_random_calibrations();
    test_output_hold();
    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_readings.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : result_sink
    int w;
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end
      w = receiver_idles ? $urandom_range(0, IdleMax) : 0;
      if (w > 0) begin
        out_stall_i <= 1'b1;
        repeat (w) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o && !hold_req);
    end
  end

  always @(posedge clk_i) begin : result_check
    reading_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_readings.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MaxReports) begin
          $display("unexpected result: milli_g %0d status %0d", milli_g_o, status_o);
        end
      end else begin
        want = pending_readings.pop_front();
        if (milli_g_o !== want.mg || status_o !== want.status) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MaxReports) begin
            $display("mismatch: expected milli_g %0d status %0d, got milli_g %0d status %0d",
                     $signed(want.mg), want.status, milli_g_o, status_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/atpm_pkg.sv
rtl/atpm_prep.sv
rtl/atpm_mul.sv
rtl/atpm_div.sv
rtl/accel_two_point_to_milli_g.sv
bench/accel_two_point_to_milli_g_tb.sv
